FILE: design/utf8rs_pkg.sv
// Shared types, constants and token expansion functions for the UTF-8 repair stream.
`timescale 1ns / 1ps

package utf8rs_pkg;

  localparam int MAX_TOKENS  = 5;
  localparam int MAX_RESULTS = 14;

  // Lead byte ranges for two, three and four byte sequences.
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Lead bytes that narrow the range of the second byte.
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hBF;

  // Replacement character U+FFFD.
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Stray bytes with a plain ASCII stand-in.
  localparam logic [7:0] STRAY_LSQUO = 8'h91;
  localparam logic [7:0] STRAY_RSQUO = 8'h92;
  localparam logic [7:0] STRAY_LDQUO = 8'h93;
  localparam logic [7:0] STRAY_RDQUO = 8'h94;
  localparam logic [7:0] STRAY_NDASH = 8'h96;
  localparam logic [7:0] STRAY_MDASH = 8'h97;
  localparam logic [7:0] STRAY_HELLIP = 8'h85;
  localparam logic [7:0] STRAY_TRADE = 8'h99;

  typedef enum logic [1:0] {
    TK_BYTE,   // one byte passed through as is
    TK_FFFD,   // the three bytes of U+FFFD
    TK_STRAY   // a stray byte, remapped
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] val;
  } token_t;

  typedef struct packed {
    logic [2:0][7:0] held;
    logic [1:0]      count;
    logic [2:0]      exp_len;
  } hold_state_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic   [3:0]            total;  // output bytes of this item, at most MAX_RESULTS
  } tok_list_t;

  function automatic logic [2:0] tok_len(input token_t t);
    logic [2:0] len;
    len = 3'd3;
    case (t.kind)
      TK_BYTE: len = 3'd1;
      TK_FFFD: len = 3'd3;
      TK_STRAY: begin
        case (t.val)
          STRAY_LSQUO, STRAY_RSQUO, STRAY_LDQUO, STRAY_RDQUO,
          STRAY_NDASH, STRAY_MDASH: len = 3'd1;
          STRAY_HELLIP: len = 3'd3;
          STRAY_TRADE: len = 3'd4;
          default: len = 3'd3;
        endcase
      end
      default: len = 3'd3;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = REPL_B0;
      2'd1: b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tok_byte(input token_t t, input logic [1:0] idx);
    logic [7:0] b;
    b = repl_byte(idx);
    case (t.kind)
      TK_BYTE: b = t.val;
      TK_FFFD: b = repl_byte(idx);
      TK_STRAY: begin
        case (t.val)
          STRAY_LSQUO, STRAY_RSQUO: b = 8'h27;
          STRAY_LDQUO, STRAY_RDQUO: b = 8'h22;
          STRAY_NDASH, STRAY_MDASH: b = 8'h2D;
          STRAY_HELLIP: b = 8'h2E;
          STRAY_TRADE: begin
            case (idx)
              2'd0: b = 8'h28;
              2'd1: b = 8'h54;
              2'd2: b = 8'h4D;
              default: b = 8'h29;
            endcase
          end
          default: b = repl_byte(idx);
        endcase
      end
      default: b = repl_byte(idx);
    endcase
    return b;
  endfunction

endpackage

FILE: design/utf8rs_decode.sv
// Classifies one input byte against the held sequence and builds its output token list.
`timescale 1ns / 1ps

module utf8rs_decode (
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  utf8rs_pkg::hold_state_t st,
  output utf8rs_pkg::hold_state_t st_nxt,
  output utf8rs_pkg::tok_list_t   list
);
  import utf8rs_pkg::*;

  always_comb begin
    token_t [MAX_TOKENS-1:0] t;
    logic [2:0]  n;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        cont_ok;
    logic        consumed;
    logic [2:0]  lead_len;
    logic [4:0]  sum;
    hold_state_t s;

    t        = '0;
    n        = 3'd0;
    s        = st;
    consumed = 1'b0;
    sum      = 5'd0;

    // Second-byte limits depend on the lead byte.
    lo = CONT_LO;
    hi = CONT_HI;
    if (st.count == 2'd1) begin
      case (st.held[0])
        LEAD_E0: lo = 8'hA0;
        LEAD_ED: hi = 8'h9F;
        LEAD_F0: lo = 8'h90;
        LEAD_F4: hi = 8'h8F;
        default: ;
      endcase
    end
    cont_ok = (in_byte >= lo) && (in_byte <= hi);

    if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
      lead_len = 3'd2;
    end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
      lead_len = 3'd3;
    end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end

    if (st.count != 2'd0) begin
      if (cont_ok) begin
        consumed = 1'b1;
        if (({1'b0, st.count} + 3'd1) >= st.exp_len) begin
          // Sequence complete: pass every held byte and this one.
          t[n] = '{kind: TK_BYTE, val: st.held[0]}; n = n + 3'd1;
          if (st.count >= 2'd2) begin
            t[n] = '{kind: TK_BYTE, val: st.held[1]}; n = n + 3'd1;
          end
          if (st.count == 2'd3) begin
            t[n] = '{kind: TK_BYTE, val: st.held[2]}; n = n + 3'd1;
          end
          t[n] = '{kind: TK_BYTE, val: in_byte}; n = n + 3'd1;
          s.count   = 2'd0;
          s.exp_len = 3'd0;
        end else begin
          if (st.count == 2'd1) begin
            s.held[1] = in_byte;
          end else begin
            s.held[2] = in_byte;
          end
          s.count = st.count + 2'd1;
        end
      end else begin
        // Broken sequence: lead becomes U+FFFD, continuations are remapped.
        t[n] = '{kind: TK_FFFD, val: st.held[0]}; n = n + 3'd1;
        if (st.count >= 2'd2) begin
          t[n] = '{kind: TK_STRAY, val: st.held[1]}; n = n + 3'd1;
        end
        if (st.count == 2'd3) begin
          t[n] = '{kind: TK_STRAY, val: st.held[2]}; n = n + 3'd1;
        end
        s.count   = 2'd0;
        s.exp_len = 3'd0;
      end
    end

    if (!consumed) begin
      if (!in_byte[7]) begin
        t[n] = '{kind: TK_BYTE, val: in_byte}; n = n + 3'd1;
      end else if (lead_len != 3'd0) begin
        s.held[0] = in_byte;
        s.count   = 2'd1;
        s.exp_len = lead_len;
      end else begin
        t[n] = '{kind: TK_STRAY, val: in_byte}; n = n + 3'd1;
      end
    end

    // At the end of the string a pending sequence is flushed as a broken one.
    if (in_last) begin
      if (s.count != 2'd0) begin
        t[n] = '{kind: TK_FFFD, val: s.held[0]}; n = n + 3'd1;
        if (s.count >= 2'd2) begin
          t[n] = '{kind: TK_STRAY, val: s.held[1]}; n = n + 3'd1;
        end
        if (s.count == 2'd3) begin
          t[n] = '{kind: TK_STRAY, val: s.held[2]}; n = n + 3'd1;
        end
      end
      s.count   = 2'd0;
      s.exp_len = 3'd0;
    end

    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (3'(i) < n) begin
        sum = sum + {2'b00, tok_len(t[i])};
      end
    end

    st_nxt     = s;
    list.tok   = t;
    list.total = (sum > 5'(MAX_RESULTS)) ? 4'(MAX_RESULTS) : sum[3:0];
  end

endmodule

FILE: design/utf8_repair_stream_core.sv
// Top level of the streaming UTF-8 validator and repairer.
`timescale 1ns / 1ps

//  Channel  Ports                                          Direction  Moves
//  -------  ---------------------------------------------  ---------  -------------------------
//  in       in_valid, in_stall, in_byte, in_last           sink       one raw string byte
//  out      out_valid, out_stall, out_byte, out_run_last,  source     one repaired UTF-8 byte
//           out_text_end
//
// An input transfer is decoded in the same cycle against the held sequence state, and the
// bytes it causes are captured as a short list of tokens (pass byte, U+FFFD, remapped stray).
// The serializer then issues one output byte per cycle while out_stall is low; an item
// yields 0 to 14 result bytes, and items that only extend a held sequence issue none.
// The single output byte per cycle, held back by out_stall, is what bounds the rate.
// Reset (rst_n low, synchronous) clears the held sequence and drops any pending result.
// While a list is being issued the input stalls, except in the cycle its final byte transfers,
// so a new item follows the last byte of the previous one without a bubble.

module utf8_repair_stream_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_end
);
  import utf8rs_pkg::*;

  // Held multi-byte sequence.
  hold_state_t st_r;
  hold_state_t st_nxt;
  hold_state_t dec_st;
  tok_list_t   dec_list;

  // Token list being issued and the position within it.
  token_t [MAX_TOKENS-1:0] tok_r, tok_nxt;
  logic [2:0] cur_r, cur_nxt;     // token being issued
  logic [1:0] idx_r, idx_nxt;     // byte within that token
  logic [3:0] cnt_r, cnt_nxt;     // bytes already issued for this item
  logic [3:0] total_r, total_nxt; // bytes this item issues
  logic       last_r, last_nxt;
  logic       busy_r, busy_nxt;

  logic   in_xfer;
  logic   out_xfer;
  logic   fin;
  token_t cur_tok;

  utf8rs_decode u_decode (
    .in_byte (in_byte),
    .in_last (in_last),
    .st      (st_r),
    .st_nxt  (dec_st),
    .list    (dec_list)
  );

  assign cur_tok  = tok_r[cur_r];
  assign fin      = (cnt_r == (total_r - 4'd1));
  assign out_xfer = busy_r && !out_stall;
  assign in_stall = busy_r && !(out_xfer && fin);
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid    = busy_r;
  assign out_byte     = tok_byte(cur_tok, idx_r);
  assign out_run_last = fin;
  assign out_text_end = fin && last_r;

  always_comb begin
    st_nxt    = st_r;
    tok_nxt   = tok_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    last_nxt  = last_r;
    busy_nxt  = busy_r;

    // Step through the current list one byte per output transfer.
    if (out_xfer) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
        if ({1'b0, idx_r} == (tok_len(cur_tok) - 3'd1)) begin
          cur_nxt = cur_r + 3'd1;
          idx_nxt = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end

    // A new item updates the held state; only items with output load the list.
    if (in_xfer) begin
      st_nxt = dec_st;
      if (dec_list.total != 4'd0) begin
        tok_nxt   = dec_list.tok;
        total_nxt = dec_list.total;
        last_nxt  = in_last;
        cur_nxt   = 3'd0;
        idx_nxt   = 2'd0;
        cnt_nxt   = 4'd0;
        busy_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      busy_r  <= 1'b0;
      cur_r   <= 3'd0;
      idx_r   <= 2'd0;
      cnt_r   <= 4'd0;
      total_r <= 4'd0;
    end else begin
      st_r    <= st_nxt;
      busy_r  <= busy_nxt;
      cur_r   <= cur_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

endmodule
